FILE: rtl/core/tvm_pkg.sv
`default_nettype none

package tvm_pkg;

	localparam int PERIOD_BITS_DEF    = 8;
	localparam int RATE_FRAC_BITS_DEF = 16;

	// Formula kinds.
	localparam logic [2:0] K_FV_LUMP = 3'd0;
	localparam logic [2:0] K_PV_LUMP = 3'd1;
	localparam logic [2:0] K_FV_ANN  = 3'd2;
	localparam logic [2:0] K_PV_ANN  = 3'd3;
	localparam logic [2:0] K_FV_DUE  = 3'd4;
	localparam logic [2:0] K_PV_DUE  = 3'd5;
	localparam logic [2:0] K_DEFER   = 3'd6;
	localparam logic [2:0] K_PERP    = 3'd7;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZDIV = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	// Scaling modes of the shared multiply-divide unit.
	localparam logic [1:0] MD_DIV  = 2'd0;
	localparam logic [1:0] MD_SH16 = 2'd1;
	localparam logic [1:0] MD_SH32 = 2'd2;

	// Destination register of a multiply-divide result.
	localparam logic [1:0] DST_ACC = 2'd0;
	localparam logic [1:0] DST_B   = 2'd1;
	localparam logic [1:0] DST_X   = 2'd2;

	localparam logic [63:0] ONE_Q    = 64'h0000_0001_0000_0000;
	localparam logic [63:0] CAP_Q    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SCALE16  = 64'h0000_0000_0001_0000;
	localparam logic [47:0] VAL_MAX  = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

FILE: rtl/core/time_value_of_money_unit_core.sv
// Time-value-of-money unit: takes one request (kind, amount, rate, periods, deferral) and
// returns one Q32.16 value with a status. The growth factor (1+r)^n is raised by squaring
// in Q32.32 on one shared multiply-divide unit; every product is built from four 32x32
// partial products. A product with a true division then runs a restoring division, one
// quotient bit per cycle. Growth takes one product per exponent bit above the lowest and
// one per set bit; up to three further operations follow. An annuity or perpetuity
// request with a zero rate takes no operation and returns a division-by-zero status; the
// deferred annuity runs two growths and three divisions.
// The unit works on one request at a time; a finished result waits in the output
// register while the next request is taken.

`default_nettype none

module time_value_of_money_unit_core #(
	parameter int PERIOD_BITS    = tvm_pkg::PERIOD_BITS_DEF,
	parameter int RATE_FRAC_BITS = tvm_pkg::RATE_FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] amount,
	input  wire logic [15:0] rate,
	input  wire logic [7:0]  periods,
	input  wire logic [7:0]  deferral,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [47:0]      value,
	output logic [1:0]       status
);

	localparam int EW    = PERIOD_BITS + 1;
	localparam int RQ_SH = 32 - RATE_FRAC_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_GROW = 4'd1;
	localparam logic [3:0] S_POST = 4'd2;
	localparam logic [3:0] S_INVD = 4'd3;
	localparam logic [3:0] S_T4   = 4'd4;
	localparam logic [3:0] S_FIN  = 4'd5;
	localparam logic [3:0] S_DONE = 4'd6;
	localparam logic [3:0] S_MUL  = 4'd7;
	localparam logic [3:0] S_ADDH = 4'd8;
	localparam logic [3:0] S_RES  = 4'd9;
	localparam logic [3:0] S_DIV  = 4'd10;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [1:0]  mode;
		logic [1:0]  dest;
		logic [3:0]  ret;
	} md_req_t;

	function automatic md_req_t mk_req(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c, input logic [1:0] mode, input logic [1:0] dest,
			input logic [3:0] ret);
		md_req_t r;
		r.a    = a;
		r.b    = b;
		r.c    = c;
		r.mode = mode;
		r.dest = dest;
		r.ret  = ret;
		return r;
	endfunction

	logic [3:0]             state_q;
	logic [2:0]             kind_q;
	logic [31:0]            amt_q;
	logic [63:0]            rq_q;
	logic [63:0]            base_q;
	logic [PERIOD_BITS-1:0] n_q;
	logic [PERIOD_BITS-1:0] d_q;
	logic [EW-1:0]          e_q;
	logic [63:0]            acc_q;
	logic [63:0]            b_q;
	logic [63:0]            x_q;
	logic [63:0]            vd_q;
	logic                   pass_q;
	logic                   sat_q;
	logic                   zdiv_q;
	md_req_t                req_q;
	logic [127:0]           prod_q;
	logic [63:0]            pp_q;
	logic [1:0]             ppsh_q;
	logic [5:0]             cnt_q;
	logic                   out_valid_q;
	logic [47:0]            value_q;
	logic [1:0]             status_q;

	logic                   accept;
	logic [63:0]            rq_in;
	logic [PERIOD_BITS-1:0] n_in;
	logic [PERIOD_BITS-1:0] d_in;
	logic [63:0]            amt64;
	logic [63:0]            a16;
	logic                   big;
	logic [31:0]            ma_h;
	logic [31:0]            mb_h;
	logic [63:0]            pp_c;
	logic [64:0]            div_rem2;
	logic                   div_qb;
	logic [64:0]            div_rem;
	logic [127:0]           q128;
	logic [63:0]            qfin;
	logic                   md_done;
	logic [63:0]            md_res;
	logic                   sat_now;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign rq_in     = 64'(rate) << RQ_SH;
	assign n_in      = PERIOD_BITS'(periods);
	assign d_in      = PERIOD_BITS'(deferral);
	assign amt64     = {32'b0, amt_q};
	assign a16       = {16'b0, amt_q, 16'b0};
	assign big       = (acc_q >= tvm_pkg::CAP_Q);
	assign ma_h      = cnt_q[1] ? req_q.a[63:32] : req_q.a[31:0];
	assign mb_h      = cnt_q[0] ? req_q.b[63:32] : req_q.b[31:0];
	assign pp_c      = {32'b0, ma_h} * {32'b0, mb_h};
	assign sat_now   = sat_q || (x_q > {16'b0, tvm_pkg::VAL_MAX});
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// One restoring step: shift the next dividend bit into the remainder.
	assign div_rem2 = {prod_q[127:64], prod_q[63]};
	assign div_qb   = (div_rem2 >= {1'b0, req_q.c});
	assign div_rem  = div_qb ? (div_rem2 - {1'b0, req_q.c}) : div_rem2;
	assign qfin     = {prod_q[62:0], div_qb};

	always_comb begin
		md_done = 1'b0;
		md_res  = '0;
		q128    = (req_q.mode == tvm_pkg::MD_SH16) ? (prod_q >> 16) : (prod_q >> 32);
		case (state_q)
			S_RES: begin
				if (req_q.mode != tvm_pkg::MD_DIV) begin
					md_done = 1'b1;
					md_res  = (q128 > {64'b0, tvm_pkg::CAP_Q}) ? tvm_pkg::CAP_Q : q128[63:0];
				end else if (req_q.c == '0 || prod_q[127:64] >= req_q.c) begin
					md_done = 1'b1;
					md_res  = tvm_pkg::CAP_Q;
				end
			end
			S_DIV: begin
				if (cnt_q == 6'd63) begin
					md_done = 1'b1;
					md_res  = (qfin > tvm_pkg::CAP_Q) ? tvm_pkg::CAP_Q : qfin;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= '0;
			amt_q       <= '0;
			rq_q        <= '0;
			base_q      <= '0;
			n_q         <= '0;
			d_q         <= '0;
			e_q         <= '0;
			acc_q       <= '0;
			b_q         <= '0;
			x_q         <= '0;
			vd_q        <= '0;
			pass_q      <= 1'b0;
			sat_q       <= 1'b0;
			zdiv_q      <= 1'b0;
			req_q       <= '0;
			prod_q      <= '0;
			pp_q        <= '0;
			ppsh_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			status_q    <= tvm_pkg::STAT_OK;
		end else begin
			// A result loaded in S_DONE takes the place of the one leaving.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q <= kind;
						amt_q  <= amount;
						rq_q   <= rq_in;
						base_q <= tvm_pkg::ONE_Q + rq_in;
						n_q    <= n_in;
						d_q    <= d_in;
						pass_q <= 1'b0;
						sat_q  <= 1'b0;
						zdiv_q <= 1'b0;
						acc_q  <= tvm_pkg::ONE_Q;
						b_q    <= tvm_pkg::ONE_Q + rq_in;
						e_q    <= (kind == tvm_pkg::K_DEFER) ? {1'b0, d_in} : {1'b0, n_in};
						if (kind >= tvm_pkg::K_FV_ANN && rate == '0) begin
							zdiv_q  <= 1'b1;
							x_q     <= '0;
							state_q <= S_DONE;
						end else if (kind == tvm_pkg::K_PERP) begin
							x_q     <= tvm_pkg::ONE_Q;
							state_q <= S_FIN;
						end else begin
							state_q <= S_GROW;
						end
					end
				end
				S_GROW: begin
					// Square-and-multiply, low exponent bit first.
					if (e_q == '0) begin
						state_q <= S_POST;
					end else if (e_q[0]) begin
						e_q     <= {e_q[EW-1:1], 1'b0};
						req_q   <= mk_req(acc_q, b_q, tvm_pkg::ONE_Q, tvm_pkg::MD_SH32,
							tvm_pkg::DST_ACC, S_GROW);
						prod_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						e_q <= e_q >> 1;
						if (e_q[EW-1:1] != '0) begin
							req_q   <= mk_req(b_q, b_q, tvm_pkg::ONE_Q, tvm_pkg::MD_SH32,
								tvm_pkg::DST_B, S_GROW);
							prod_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_MUL;
						end
					end
				end
				S_POST: begin
					case (kind_q)
						tvm_pkg::K_FV_LUMP, tvm_pkg::K_FV_ANN, tvm_pkg::K_FV_DUE: begin
							if (big) begin
								sat_q   <= (amt_q != '0);
								x_q     <= '0;
								state_q <= S_DONE;
							end else if (kind_q == tvm_pkg::K_FV_LUMP) begin
								req_q   <= mk_req(amt64, acc_q, tvm_pkg::SCALE16,
									tvm_pkg::MD_SH16, tvm_pkg::DST_X, S_DONE);
								prod_q  <= '0;
								cnt_q   <= '0;
								state_q <= S_MUL;
							end else if (kind_q == tvm_pkg::K_FV_ANN) begin
								x_q     <= acc_q - tvm_pkg::ONE_Q;
								state_q <= S_FIN;
							end else begin
								req_q   <= mk_req(acc_q - tvm_pkg::ONE_Q, base_q,
									tvm_pkg::ONE_Q, tvm_pkg::MD_SH32, tvm_pkg::DST_X, S_T4);
								prod_q  <= '0;
								cnt_q   <= '0;
								state_q <= S_MUL;
							end
						end
						default: begin
							// Discount factor 1/G; a clamped growth discounts to zero.
							if (big) begin
								x_q     <= '0;
								state_q <= S_INVD;
							end else begin
								req_q   <= mk_req(tvm_pkg::ONE_Q, tvm_pkg::ONE_Q, acc_q,
									tvm_pkg::MD_DIV, tvm_pkg::DST_X, S_INVD);
								prod_q  <= '0;
								cnt_q   <= '0;
								state_q <= S_MUL;
							end
						end
					endcase
				end
				S_T4: begin
					if (x_q >= tvm_pkg::CAP_Q) begin
						sat_q   <= (amt_q != '0);
						x_q     <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_INVD: begin
					case (kind_q)
						tvm_pkg::K_PV_LUMP: begin
							req_q   <= mk_req(amt64, x_q, tvm_pkg::SCALE16, tvm_pkg::MD_SH16,
								tvm_pkg::DST_X, S_DONE);
							prod_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_MUL;
						end
						tvm_pkg::K_PV_ANN: begin
							x_q     <= tvm_pkg::ONE_Q - x_q;
							state_q <= S_FIN;
						end
						tvm_pkg::K_PV_DUE: begin
							req_q   <= mk_req(tvm_pkg::ONE_Q - x_q, base_q, tvm_pkg::ONE_Q,
								tvm_pkg::MD_SH32, tvm_pkg::DST_X, S_FIN);
							prod_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_MUL;
						end
						default: begin
							// Deferred annuity: first pass discounts over the deferral,
							// second pass over deferral plus payment periods.
							if (!pass_q) begin
								vd_q    <= x_q;
								pass_q  <= 1'b1;
								acc_q   <= tvm_pkg::ONE_Q;
								b_q     <= base_q;
								e_q     <= {1'b0, d_q} + {1'b0, n_q};
								state_q <= S_GROW;
							end else begin
								x_q     <= (vd_q > x_q) ? (vd_q - x_q) : '0;
								state_q <= S_FIN;
							end
						end
					endcase
				end
				S_FIN: begin
					req_q   <= mk_req(a16, x_q, rq_q, tvm_pkg::MD_DIV, tvm_pkg::DST_X, S_DONE);
					prod_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (zdiv_q) begin
							value_q  <= tvm_pkg::VAL_MAX;
							status_q <= tvm_pkg::STAT_ZDIV;
						end else if (sat_now) begin
							value_q  <= tvm_pkg::VAL_MAX;
							status_q <= tvm_pkg::STAT_SAT;
						end else begin
							value_q  <= x_q[47:0];
							status_q <= tvm_pkg::STAT_OK;
						end
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					// Partial products are registered and summed in the next cycle.
					if (cnt_q <= 6'd3) begin
						pp_q   <= pp_c;
						ppsh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
					end
					if (cnt_q != '0) begin
						prod_q <= prod_q + ({64'b0, pp_q} << {ppsh_q, 5'b0});
					end
					if (cnt_q == 6'd4) begin
						state_q <= S_ADDH;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_ADDH: begin
					prod_q  <= prod_q + {65'b0, req_q.c[63:1]};
					state_q <= S_RES;
				end
				S_RES: begin
					if (!md_done) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					prod_q <= {div_rem[63:0], qfin};
					cnt_q  <= cnt_q + 6'd1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (md_done) begin
				case (req_q.dest)
					tvm_pkg::DST_ACC: acc_q <= md_res;
					tvm_pkg::DST_B:   b_q   <= md_res;
					default:          x_q   <= md_res;
				endcase
				state_q <= req_q.ret;
			end
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted but the sequencer stayed idle");

	a_flag_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != tvm_pkg::STAT_OK |-> value_q == tvm_pkg::VAL_MAX)
		else $error("flagged result is not saturated");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> prod_q[127:64] < req_q.c)
		else $error("division remainder reached the divisor");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == S_RES || state_q == S_DIV)
		else $error("multiply-divide result outside the unit states");

endmodule

`default_nettype wire

FILE: tb/sv/tb_time_value_of_money_unit_core.sv
`default_nettype none

module tb_time_value_of_money_unit_core;
	import tvm_pkg::*;

	localparam int     CLK_HALF     = 6;
	localparam int     RANDOM_ITEMS = 1750;
	localparam int     QUIET_ITEMS  = 200;
	localparam int     HOLD_AT      = 400;
	localparam int     PAUSE_AT     = 900;
	localparam int     HOLD_CYCLES  = 3000;
	localparam int     DRAIN_CYCLES = 600;
	localparam longint LIMIT_TIME   = 64'd48_000_000;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] amount;
		logic [15:0] rate;
		logic [7:0]  periods;
		logic [7:0]  deferral;
	} request_t;

	typedef struct {
		logic [47:0] value;
		logic [1:0]  status;
	} result_t;

	typedef struct {
		request_t req;
		logic     typed;
		result_t  res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] kind;
	logic [31:0] amount;
	logic [15:0] rate;
	logic [7:0] periods;
	logic [7:0] deferral;
	logic out_valid;
	logic out_stall;
	logic [47:0] value;
	logic [1:0] status;

	result_t   pending_values[$];
	stim_row_t directed_rows[$];
	result_t   want;
	int        errors = 0;
	logic      idle_on = 1'b0;
	logic      hold_req = 1'b0;

	time_value_of_money_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.amount    (amount),
		.rate      (rate),
		.periods   (periods),
		.deferral  (deferral),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

	always #CLK_HALF clk = ~clk;

	// Rounded (a*b + c/2) / c over 128 bits, clamped at the Q32.32 cap.
	function automatic logic [63:0] mul_round_div(logic [63:0] a, logic [63:0] b,
		logic [63:0] c);
		logic [127:0] prod;
		logic [127:0] quo;
		if (c == 64'd0)
			return CAP_Q;
		prod = 128'(a) * 128'(b) + 128'(c >> 1);
		if (prod[127:64] >= c)
			return CAP_Q;
		quo = prod / 128'(c);
		return (quo[63:0] > CAP_Q) ? CAP_Q : quo[63:0];
	endfunction

	function automatic logic [63:0] growth(logic [63:0] base, logic [31:0] e);
		logic [63:0] acc;
		logic [63:0] b;
		acc = ONE_Q;
		b = base;
		while (e != 32'd0) begin
			if (e[0])
				acc = mul_round_div(acc, b, ONE_Q);
			e = e >> 1;
			if (e != 32'd0)
				b = mul_round_div(b, b, ONE_Q);
		end
		return acc;
	endfunction

	function automatic logic [63:0] discount(logic [63:0] g);
		return (g >= CAP_Q) ? 64'd0 : mul_round_div(ONE_Q, ONE_Q, g);
	endfunction

	function automatic result_t predict_time_value(request_t req);
		logic [31:0] pmask;
		logic [31:0] n;
		logic [31:0] d;
		logic [63:0] rq;
		logic [63:0] base;
		logic [63:0] a16;
		logic [63:0] g;
		logic [63:0] v;
		logic [63:0] t;
		logic [63:0] vd;
		logic [63:0] vdn;
		logic [63:0] val;
		logic        ovf;
		result_t     res;
		pmask = (32'd1 << PERIOD_BITS_DEF) - 32'd1;
		n = 32'(req.periods) & pmask;
		d = 32'(req.deferral) & pmask;
		rq = 64'(req.rate) << (32 - RATE_FRAC_BITS_DEF);
		base = ONE_Q + rq;
		a16 = 64'(req.amount) << 16;
		val = 64'd0;
		ovf = 1'b0;
		res.status = STAT_OK;
		if (req.kind >= K_FV_ANN && req.rate == 16'd0) begin
			res.value = VAL_MAX;
			res.status = STAT_ZDIV;
			return res;
		end
		g = growth(base, n);
		case (req.kind)
			K_FV_LUMP: begin
				if (g >= CAP_Q)
					ovf = (req.amount != 32'd0);
				else
					val = mul_round_div(64'(req.amount), g, SCALE16);
			end
			K_PV_LUMP: val = mul_round_div(64'(req.amount), discount(g), SCALE16);
			K_FV_ANN: begin
				if (g >= CAP_Q)
					ovf = (req.amount != 32'd0);
				else
					val = mul_round_div(a16, g - ONE_Q, rq);
			end
			K_PV_ANN: val = mul_round_div(a16, ONE_Q - discount(g), rq);
			K_FV_DUE: begin
				t = (g >= CAP_Q) ? CAP_Q : mul_round_div(g - ONE_Q, base, ONE_Q);
				if (t >= CAP_Q)
					ovf = (req.amount != 32'd0);
				else
					val = mul_round_div(a16, t, rq);
			end
			K_PV_DUE: begin
				v = discount(g);
				t = mul_round_div(ONE_Q - v, base, ONE_Q);
				val = mul_round_div(a16, t, rq);
			end
			K_DEFER: begin
				vd = discount(growth(base, d));
				vdn = discount(growth(base, d + n));
				// Rounding can push the longer discount above the shorter one.
				val = mul_round_div(a16, (vd > vdn) ? vd - vdn : 64'd0, rq);
			end
			default: val = mul_round_div(a16, ONE_Q, rq);
		endcase
		if (ovf || val > 64'(VAL_MAX)) begin
			res.value = VAL_MAX;
			res.status = STAT_SAT;
		end else begin
			res.value = val[47:0];
		end
		return res;
	endfunction

	function automatic void add_row(logic [2:0] k, logic [31:0] amt, logic [15:0] r,
		logic [7:0] n, logic [7:0] d, logic typed, logic [47:0] v, logic [1:0] s);
		stim_row_t row;
		row.req.kind = k;
		row.req.amount = amt;
		row.req.rate = r;
		row.req.periods = n;
		row.req.deferral = d;
		row.typed = typed;
		row.res.value = v;
		row.res.status = s;
		directed_rows.push_back(row);
	endfunction

	function automatic request_t random_request();
		request_t req;
		req.kind = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 7))
			0: req.amount = 32'd0;
			1: req.amount = 32'hFFFF_FFFF;
			2: req.amount = 32'($urandom_range(0, 1000));
			default: req.amount = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0: req.rate = 16'd0;
			1: req.rate = 16'hFFFF;
			2: req.rate = 16'($urandom_range(1, 64));
			3, 4: req.rate = 16'($urandom_range(1, 2000));
			default: req.rate = 16'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: req.periods = 8'd0;
			1: req.periods = 8'hFF;
			2, 3: req.periods = 8'($urandom_range(1, 30));
			default: req.periods = 8'($urandom);
		endcase
		req.deferral = 8'($urandom);
		return req;
	endfunction

	// Drives one request from a falling edge and returns at the falling edge after it is taken.
	task automatic offer_request(input request_t req, input result_t res);
		in_valid <= 1'b1;
		kind <= req.kind;
		amount <= req.amount;
		rate <= req.rate;
		periods <= req.periods;
		deferral <= req.deferral;
		do
			@(posedge clk);
		while (in_stall);
		pending_values.push_back(res);
		@(negedge clk);
	endtask

	initial begin
		request_t  req;
		result_t   res;
		stim_row_t row;
		int        total;
		int        gap;
		in_valid = 1'b0;
		kind = K_FV_LUMP;
		amount = 32'd0;
		rate = 16'd0;
		periods = 8'd0;
		deferral = 8'd0;
		arst_n = 1'b0;

		add_row(K_FV_LUMP, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1, 48'd0, STAT_OK);
		add_row(K_FV_LUMP, 32'd1, 16'd0, 8'd5, 8'd0, 1'b1, 48'd65536, STAT_OK);
		add_row(K_PV_LUMP, 32'd7, 16'd0, 8'd200, 8'd0, 1'b1, 48'd458752, STAT_OK);
		add_row(K_FV_ANN, 32'hFFFF_FFFF, 16'd0, 8'd10, 8'd0, 1'b1, VAL_MAX, STAT_ZDIV);
		add_row(K_PV_ANN, 32'd0, 16'd0, 8'd255, 8'd0, 1'b1, VAL_MAX, STAT_ZDIV);
		add_row(K_FV_DUE, 32'd5, 16'd0, 8'd1, 8'd0, 1'b1, VAL_MAX, STAT_ZDIV);
		add_row(K_PV_DUE, 32'd9, 16'd0, 8'd3, 8'd0, 1'b1, VAL_MAX, STAT_ZDIV);
		add_row(K_DEFER, 32'hFFFF_FFFF, 16'd0, 8'd255, 8'd255, 1'b1, VAL_MAX, STAT_ZDIV);
		add_row(K_PERP, 32'd100, 16'd0, 8'd0, 8'd0, 1'b1, VAL_MAX, STAT_ZDIV);
		add_row(K_FV_LUMP, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd0, 1'b1, VAL_MAX, STAT_SAT);
		add_row(K_FV_LUMP, 32'd0, 16'hFFFF, 8'd255, 8'd0, 1'b1, 48'd0, STAT_OK);
		add_row(K_FV_ANN, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd0, 1'b1, VAL_MAX, STAT_SAT);
		add_row(K_FV_DUE, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd0, 1'b1, VAL_MAX, STAT_SAT);
		add_row(K_FV_DUE, 32'd0, 16'hFFFF, 8'd255, 8'd0, 1'b1, 48'd0, STAT_OK);
		add_row(K_PV_LUMP, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd0, 1'b1, 48'd0, STAT_OK);
		add_row(K_PERP, 32'd1, 16'h8000, 8'd0, 8'd0, 1'b1, 48'd131072, STAT_OK);
		add_row(K_PERP, 32'hFFFF_FFFF, 16'd1, 8'd0, 8'd0, 1'b1, VAL_MAX, STAT_SAT);
		add_row(K_DEFER, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd255, 1'b1, 48'd0, STAT_OK);
		add_row(K_FV_ANN, 32'd1000, 16'h0100, 8'd0, 8'd0, 1'b1, 48'd0, STAT_OK);
		add_row(K_PV_ANN, 32'd1000, 16'h0100, 8'd0, 8'd0, 1'b1, 48'd0, STAT_OK);
		add_row(K_FV_LUMP, 32'd1000, 16'h0290, 8'd12, 8'd0, 1'b0, 48'd0, STAT_OK);
		add_row(K_FV_ANN, 32'd250, 16'h0400, 8'd36, 8'd0, 1'b0, 48'd0, STAT_OK);
		add_row(K_PV_DUE, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd0, 1'b0, 48'd0, STAT_OK);
		add_row(K_DEFER, 32'd5000, 16'd1, 8'd1, 8'd200, 1'b0, 48'd0, STAT_OK);
		add_row(K_DEFER, 32'd777, 16'h0800, 8'd20, 8'd0, 1'b0, 48'd0, STAT_OK);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		total = directed_rows.size() + RANDOM_ITEMS;
		for (int i = 0; i < total; i++) begin
			if (i % 64 == 0)
				idle_on = (total - i > QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
			if (i == HOLD_AT)
				hold_req = 1'b1;
			if (i == PAUSE_AT) begin
				// Let the unit drain completely before going on.
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending_values.size() != 0)
					@(negedge clk);
			end else if (i != 0 && idle_on && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 9);
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			if (i < directed_rows.size()) begin
				row = directed_rows[i];
				req = row.req;
				res = row.typed ? row.res : predict_time_value(req);
			end else begin
				req = random_request();
				res = predict_time_value(req);
			end
			offer_request(req, res);
		end
		in_valid <= 1'b0;
		idle_on = 1'b0;

		while (pending_values.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[time_value_of_money_unit_core] OK");
		else
			$display("[time_value_of_money_unit_core] ERROR");
		$finish;
	end

	// Result side: random stall bursts plus one long hold-off that backs the unit up.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_values.size() == 0) begin
				$error("unexpected result: value %h status %0d", value, status);
				errors++;
			end else begin
				want = pending_values.pop_front();
				if (value !== want.value) begin
					$error("value: expected %h, got %h", want.value, value);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
			end
		end
	end

	initial begin
		#(LIMIT_TIME);
		$display("[time_value_of_money_unit_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/tvm_pkg.sv
rtl/core/time_value_of_money_unit_core.sv
tb/sv/tb_time_value_of_money_unit_core.sv
